[hdl/sorted_table_binary_search_insert_unit_assert.svh]
// Assertion macros shared by the sorted table search and insert unit.
`ifndef SORTED_TABLE_BINARY_SEARCH_INSERT_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_INSERT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_IMM(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/stbs_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
package stbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam int OP_W        = 2;
    localparam int SLOT_W      = 8;
    localparam int POS_W       = 9;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;

    localparam int S_TDATA_W   = ((KEY_WIDTH + SLOT_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_PAYLOAD_W = POS_W + 1 + STATUS_W + COUNT_OUT_W + KEY_WIDTH;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_SLOT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_DATA,
        ST_FIRST_CMP,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_RESOLVE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_PRIME,
        ST_SHIFT,
        ST_WRITE_KEY,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_SLOT,
        RD_MID,
        RD_PTR,
        RD_TOP,
        RD_SHIFT
    } rd_sel_t;

    typedef struct packed {
        logic    latch;
        rd_sel_t rd_sel;
        logic    res_full;
        logic    res_bad_slot;
        logic    res_read;
        logic    res_find;
        logic    idx_below;
        logic    search_init;
        logic    probe_issue;
        logic    probe_gt;
        logic    probe_lt;
        logic    probe_eq;
        logic    probe_end;
        logic    ptr_from_idx;
        logic    ptr_inc;
        logic    ins_from_idx;
        logic    ins_from_ptr;
        logic    ins_zero;
        logic    shift_start;
        logic    shift_step;
        logic    write_key;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            count_full;
        logic            slot_ok;
        logic            key_lt;
        logic            key_eq;
        logic            lo_gt_hi;
        logic            eq;
        logic            ptr_lt_count;
        logic            ins_lt_count;
        logic            shift_last;
        logic            out_free;
    } dp_stat_t;

endpackage

[hdl/stbs_dp.sv]
// Datapath: key table memory, search registers, result staging and output register.
`include "sorted_table_binary_search_insert_unit_assert.svh"

module stbs_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  stbs_pkg::dp_cmd_t               cmd,
    input  logic [stbs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [stbs_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata,
    output stbs_pkg::dp_stat_t              st
);
    import stbs_pkg::*;

    logic [KEY_WIDTH-1:0] table_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rdata_reg;

    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     mid_reg, mid_next;
    logic                 cmp_lt_reg, cmp_lt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 eq_reg, eq_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     ins_reg, ins_next;

    logic [POS_W-1:0]     res_pos_reg, res_pos_next;
    logic                 res_found_reg, res_found_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [KEY_WIDTH-1:0] res_rkey_reg, res_rkey_next;

    logic                   out_valid_reg, out_valid_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;
    logic                   out_found_reg, out_found_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic [KEY_WIDTH-1:0]   out_rkey_reg, out_rkey_next;

    logic [CNT_W:0]       lo_hi_sum;
    logic [IDX_W-1:0]     mid_calc;
    logic [CNT_W-1:0]     cnt_m1;
    logic [CNT_W-1:0]     ptr_m2;
    logic [CNT_W-1:0]     ins_p1;
    logic [CNT_W-1:0]     idx_p1;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = lo_hi_sum[IDX_W:1];
    assign cnt_m1    = count_reg - 1'b1;
    assign ptr_m2    = ptr_reg - 2'd2;
    assign ins_p1    = ins_reg + 1'b1;
    assign idx_p1    = idx_reg + 1'b1;

    always_comb begin
        unique case (cmd.rd_sel)
            RD_ZERO:  rd_addr = '0;
            RD_SLOT:  rd_addr = IDX_W'(slot_reg);
            RD_MID:   rd_addr = mid_calc;
            RD_PTR:   rd_addr = ptr_reg[IDX_W-1:0];
            RD_TOP:   rd_addr = cnt_m1[IDX_W-1:0];
            RD_SHIFT: rd_addr = ptr_m2[IDX_W-1:0];
            default:  rd_addr = '0;
        endcase
    end

    assign mem_we  = cmd.shift_step | cmd.write_key;
    assign wr_addr = cmd.shift_step ? ptr_reg[IDX_W-1:0] : ins_reg[IDX_W-1:0];
    assign wr_data = cmd.shift_step ? rdata_reg : key_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= table_mem[rd_addr];
    end

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        cmp_lt_next     = cmp_lt_reg;
        idx_next        = idx_reg;
        eq_next         = eq_reg;
        ptr_next        = ptr_reg;
        ins_next        = ins_reg;
        res_pos_next    = res_pos_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_rkey_next   = res_rkey_reg;

        if (cmd.latch) begin
            op_next         = s_tuser[OP_W-1:0];
            key_next        = s_tdata[KEY_WIDTH-1:0];
            slot_next       = s_tdata[KEY_WIDTH +: SLOT_W];
            res_pos_next    = '0;
            res_found_next  = 1'b0;
            res_status_next = STAT_OK;
            res_rkey_next   = '0;
        end
        if (cmd.res_full) begin
            res_status_next = STAT_FULL;
        end
        if (cmd.res_bad_slot) begin
            res_status_next = STAT_BAD_SLOT;
        end
        if (cmd.res_read) begin
            res_pos_next  = POS_W'(slot_reg);
            res_rkey_next = rdata_reg;
        end
        if (cmd.res_find) begin
            res_pos_next   = POS_W'(idx_reg);
            res_found_next = eq_reg;
        end
        if (cmd.write_key) begin
            res_pos_next = POS_W'(ins_reg);
            count_next   = count_reg + 1'b1;
        end
        if (cmd.idx_below) begin
            idx_next = '1;
            eq_next  = 1'b0;
        end
        if (cmd.search_init) begin
            lo_next     = '0;
            hi_next     = cnt_m1;
            cmp_lt_next = 1'b0;
        end
        if (cmd.probe_issue) begin
            mid_next = mid_calc;
        end
        if (cmd.probe_gt) begin
            lo_next     = CNT_W'(mid_reg) + 1'b1;
            cmp_lt_next = 1'b0;
        end
        if (cmd.probe_lt) begin
            hi_next     = CNT_W'(mid_reg) - 1'b1;
            cmp_lt_next = 1'b1;
        end
        if (cmd.probe_eq) begin
            idx_next = CNT_W'(mid_reg);
            eq_next  = 1'b1;
        end
        if (cmd.probe_end) begin
            // Step back one place when the last probe landed above the key.
            idx_next = (mid_reg != '0 && cmp_lt_reg) ? CNT_W'(mid_reg) - 1'b1
                                                     : CNT_W'(mid_reg);
            eq_next  = 1'b0;
        end
        if (cmd.ptr_from_idx) begin
            ptr_next = idx_p1;
        end
        if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + 1'b1;
        end
        if (cmd.ins_from_idx) begin
            ins_next = idx_p1;
        end
        if (cmd.ins_from_ptr) begin
            ins_next = ptr_reg;
        end
        if (cmd.ins_zero) begin
            ins_next = '0;
        end
        if (cmd.shift_start) begin
            ptr_next = count_reg;
        end
        if (cmd.shift_step) begin
            ptr_next = ptr_reg - 1'b1;
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_rkey_next   = out_rkey_reg;
        if (cmd.out_load) begin
            out_valid_next  = 1'b1;
            out_pos_next    = res_pos_reg;
            out_found_next  = res_found_reg;
            out_status_next = res_status_reg;
            out_count_next  = COUNT_OUT_W'(count_reg);
            out_rkey_next   = res_rkey_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        cmp_lt_reg     <= cmp_lt_next;
        idx_reg        <= idx_next;
        eq_reg         <= eq_next;
        ptr_reg        <= ptr_next;
        ins_reg        <= ins_next;
        res_pos_reg    <= res_pos_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_rkey_reg   <= res_rkey_next;
        out_pos_reg    <= out_pos_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_rkey_reg   <= out_rkey_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_rkey_reg, out_count_reg, out_status_reg,
                                  out_found_reg, out_pos_reg});

    assign st.op           = op_reg;
    assign st.count_zero   = (count_reg == '0);
    assign st.count_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign st.slot_ok      = (CNT_W'(slot_reg) < count_reg);
    assign st.key_lt       = (key_reg < rdata_reg);
    assign st.key_eq       = (key_reg == rdata_reg);
    assign st.lo_gt_hi     = (lo_reg > hi_reg);
    assign st.eq           = eq_reg;
    assign st.ptr_lt_count = (ptr_reg < count_reg);
    assign st.ins_lt_count = (ins_reg < count_reg);
    assign st.shift_last   = (ptr_reg == ins_p1);
    assign st.out_free     = !out_valid_reg || m_tready;

    `STBS_ASSERT_IMM(a_probe_in_range, aclk, aresetn, cmd.probe_issue, CNT_W'(rd_addr) < count_reg, "probe outside stored entries")
    `STBS_ASSERT_IMM(a_shift_above_ins, aclk, aresetn, cmd.shift_step, ptr_reg > ins_reg, "shift ran past insert point")
    `STBS_ASSERT_NEXT(a_count_grows, aclk, aresetn, cmd.write_key, count_reg == $past(count_reg) + 1'b1, "count not advanced on insert")

endmodule

[hdl/stbs_ctrl.sv]
// Controller: sequences search, scan, shift and result delivery for one operation.
`include "sorted_table_binary_search_insert_unit_assert.svh"

module stbs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  stbs_pkg::dp_stat_t st,
    output stbs_pkg::dp_cmd_t  cmd
);
    import stbs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (st.op)
                    OP_INSERT: begin
                        if (st.count_full)      state_next = ST_FINISH;
                        else if (st.count_zero) state_next = ST_WRITE_KEY;
                        else                    state_next = ST_FIRST_CMP;
                    end
                    OP_FIND: begin
                        state_next = st.count_zero ? ST_RESOLVE : ST_FIRST_CMP;
                    end
                    OP_READ: begin
                        state_next = st.slot_ok ? ST_READ_DATA : ST_FINISH;
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_READ_DATA:  state_next = ST_FINISH;
            ST_FIRST_CMP:  state_next = st.key_lt ? ST_RESOLVE : ST_PROBE_RD;
            ST_PROBE_RD:   state_next = st.lo_gt_hi ? ST_RESOLVE : ST_PROBE_CMP;
            ST_PROBE_CMP:  state_next = st.key_eq ? ST_RESOLVE : ST_PROBE_RD;
            ST_RESOLVE: begin
                if (st.op == OP_FIND) state_next = ST_FINISH;
                else if (st.eq)       state_next = ST_SCAN_RD;
                else                  state_next = ST_SHIFT_PRIME;
            end
            ST_SCAN_RD:     state_next = st.ptr_lt_count ? ST_SCAN_CMP : ST_SHIFT_PRIME;
            ST_SCAN_CMP:    state_next = st.key_eq ? ST_SCAN_RD : ST_SHIFT_PRIME;
            ST_SHIFT_PRIME: state_next = st.ins_lt_count ? ST_SHIFT : ST_WRITE_KEY;
            ST_SHIFT: begin
                if (st.shift_last) state_next = ST_WRITE_KEY;
            end
            ST_WRITE_KEY: state_next = ST_FINISH;
            ST_FINISH: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            ST_DISPATCH: begin
                unique case (st.op)
                    OP_INSERT: begin
                        if (st.count_full)      cmd.res_full = 1'b1;
                        else if (st.count_zero) cmd.ins_zero = 1'b1;
                        else                    cmd.rd_sel   = RD_ZERO;
                    end
                    OP_FIND: begin
                        cmd.idx_below = st.count_zero;
                        cmd.rd_sel    = RD_ZERO;
                    end
                    OP_READ: begin
                        cmd.res_bad_slot = !st.slot_ok;
                        cmd.rd_sel       = RD_SLOT;
                    end
                    default: cmd.rd_sel = RD_ZERO;
                endcase
            end
            ST_READ_DATA: cmd.res_read = 1'b1;
            ST_FIRST_CMP: begin
                cmd.idx_below   = st.key_lt;
                cmd.search_init = !st.key_lt;
            end
            ST_PROBE_RD: begin
                cmd.probe_end   = st.lo_gt_hi;
                cmd.probe_issue = !st.lo_gt_hi;
                cmd.rd_sel      = RD_MID;
            end
            ST_PROBE_CMP: begin
                cmd.probe_eq = st.key_eq;
                cmd.probe_lt = st.key_lt;
                cmd.probe_gt = !st.key_eq && !st.key_lt;
            end
            ST_RESOLVE: begin
                if (st.op == OP_FIND) cmd.res_find     = 1'b1;
                else if (st.eq)       cmd.ptr_from_idx = 1'b1;
                else                  cmd.ins_from_idx = 1'b1;
            end
            ST_SCAN_RD: begin
                cmd.ins_from_ptr = !st.ptr_lt_count;
                cmd.rd_sel       = RD_PTR;
            end
            ST_SCAN_CMP: begin
                cmd.ptr_inc      = st.key_eq;
                cmd.ins_from_ptr = !st.key_eq;
            end
            ST_SHIFT_PRIME: begin
                cmd.shift_start = st.ins_lt_count;
                cmd.rd_sel      = RD_TOP;
            end
            ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                cmd.rd_sel     = RD_SHIFT;
            end
            ST_WRITE_KEY: cmd.write_key = 1'b1;
            ST_FINISH:    cmd.out_load  = st.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

    `STBS_ASSERT_IMM(a_load_when_free, aclk, aresetn, cmd.out_load, st.out_free, "result loaded over an undelivered transfer")

endmodule

[hdl/sorted_table_binary_search_insert_unit.sv]
// Read returns the key stored at a slot; find is a binary search of at most 9 probes.
// Insert: find, scan past each equal key, move each later entry up one place, write the key.
// The key memory takes one read and one write a cycle and has a registered read.
// Throughput: one operation at a time; the next transfer is taken once the result is
// staged in the output register, even while that result still waits for m_tready.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
`include "sorted_table_binary_search_insert_unit_assert.svh"

module sorted_table_binary_search_insert_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Operation request
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stbs_pkg::S_TDATA_W-1:0]  s_tdata,  // key[31:0], slot[39:32]
    input  logic [stbs_pkg::S_TUSER_W-1:0]  s_tuser,  // op[1:0]
    // Operation result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata   // position[8:0], found[9],
                                                      // status[11:10], entry_count[20:12],
                                                      // read_key[52:21], zero[55:53]
);
    import stbs_pkg::*;

    // Command and status between the sequencer and the table datapath.
    dp_cmd_t  cmd;
    dp_stat_t st;

    // Sequencer: one state per probe half and per scan half, and one per shift step.
    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: key memory, search bounds, insert pointer and output register.
    stbs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .st       (st)
    );

    // Hold off further requests for at least the cycle after each accepted transfer.
    `STBS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second transfer taken while busy")

endmodule

[tb/tb.sv]
// Self-checking stream testbench for the sorted key table with search, insert and read.
module tb;
    import stbs_pkg::*;

    // Op code three has no member in op_t; the block treats it as a no-operation.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Bit offsets of the result fields inside m_tdata, lowest field first.
    localparam int FOUND_BIT  = POS_W;
    localparam int STATUS_LSB = POS_W + 1;
    localparam int COUNT_LSB  = STATUS_LSB + STATUS_W;
    localparam int RKEY_LSB   = COUNT_LSB + COUNT_OUT_W;

    // Items per random burst; three bursts, one per idling pattern.
    localparam int BURST_ITEMS = 430;
    // Longest insert walks a full run of equal keys and shifts the whole table.
    localparam int DRAIN_CYCLES = 1000;
    // Receiver hold-off, long enough to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic signed [POS_W-1:0]       position;
        logic                          found;
        status_t                       status;
        logic        [COUNT_OUT_W-1:0] entry_count;
        logic        [KEY_WIDTH-1:0]   read_key;
    } outcome_t;

    typedef struct packed {
        logic     [OP_W-1:0]      op;
        logic     [KEY_WIDTH-1:0] key;
        logic     [SLOT_W-1:0]    slot;
        logic                     typed;   // use the hand-written outcome below
        outcome_t                 want;
    } op_request_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the table, kept in step with every accepted operation.
    logic [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];
    int                   table_count = 0;

    outcome_t    pending_outcomes [$];
    op_request_t directed [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_off_req = 1'b0;
    int hold_left = 0;
    bit hold_off_done = 1'b0;
    int fail_count = 0;
    int results_seen = 0;

    sorted_table_binary_search_insert_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // key[31:0], slot[39:32]
        .s_tuser  (s_tuser),   // op[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // position[8:0], found[9], status[11:10],
                               // entry_count[20:12], read_key[52:21]
    );

    always #5 aclk = ~aclk;

    // Binary search over the shadow table. Return the index of an equal key,
    // else the greatest index holding a smaller key, else -1.
    function automatic int search_table(logic [KEY_WIDTH-1:0] k, output bit hit);
        int lo;
        int hi;
        int mid;
        int dir;
        hit = 1'b0;
        mid = 0;
        dir = 0;
        if (table_count == 0 || k < key_table[0]) return -1;
        lo = 0;
        hi = table_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (k > key_table[mid]) begin
                dir = 1;
                lo = mid + 1;
            end else if (k == key_table[mid]) begin
                hit = 1'b1;
                return mid;
            end else begin
                dir = -1;
                hi = mid - 1;
            end
        end
        // The last probe overshot upward: step back to the smaller neighbor.
        if (mid > 0 && dir < 0) mid--;
        return mid;
    endfunction

    // Apply one operation to the shadow table and return the result it produces.
    function automatic outcome_t apply_operation(logic [OP_W-1:0] op,
                                                 logic [KEY_WIDTH-1:0] k,
                                                 logic [SLOT_W-1:0] s);
        outcome_t r;
        int at;
        bit hit;
        r.position = '0;
        r.found    = 1'b0;
        r.status   = STAT_OK;
        r.read_key = '0;
        case (op)
            OP_INSERT: begin
                if (table_count >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    at = 0;
                    if (table_count != 0) begin
                        at = search_table(k, hit) + 1;
                        // Land after the whole run of equal keys.
                        if (hit) begin
                            while (at < table_count && key_table[at] == k) at++;
                        end
                    end
                    for (int j = table_count; j > at; j--) key_table[j] = key_table[j-1];
                    key_table[at] = k;
                    table_count++;
                    r.position = POS_W'(at);
                end
            end
            OP_FIND: begin
                r.position = POS_W'(search_table(k, hit));
                r.found    = hit;
            end
            OP_READ: begin
                if (int'(s) < table_count) begin
                    r.position = POS_W'(s);
                    r.read_key = key_table[s];
                end else begin
                    r.status = STAT_BAD_SLOT;
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_OUT_W'(table_count);
        return r;
    endfunction

    function automatic op_request_t make_row(logic [OP_W-1:0] op, logic [KEY_WIDTH-1:0] k,
                                             logic [SLOT_W-1:0] s, logic typed, int pos,
                                             status_t st, int cnt);
        op_request_t row;
        row.op                = op;
        row.key               = k;
        row.slot              = s;
        row.typed             = typed;
        row.want.position     = POS_W'(pos);
        row.want.found        = 1'b0;
        row.want.status       = st;
        row.want.entry_count  = COUNT_OUT_W'(cnt);
        row.want.read_key     = '0;
        return row;
    endfunction

    // Often keys near what is stored, so finds hit and inserts build runs of duplicates.
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35 && table_count != 0)
            return key_table[$urandom_range(table_count - 1)];
        if (pick < 40 && table_count != 0)
            return key_table[$urandom_range(table_count - 1)] + 32'd1;
        if (pick < 45 && table_count != 0)
            return key_table[$urandom_range(table_count - 1)] - 32'd1;
        if (pick < 65)
            return KEY_WIDTH'($urandom_range(15));
        if (pick < 72)
            return 32'hFFFF_FFF0 | KEY_WIDTH'($urandom_range(15));
        return $urandom;
    endfunction

    // Offer one operation; predict and queue its result once the transfer is certain.
    task automatic send_op(op_request_t row);
        outcome_t predicted;
        // Idle for a random gap before this item.
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({row.slot, row.key});
        s_tuser  <= row.op;
        // s_tready only moves at rising edges, so the falling edge shows what the
        // next rising edge will see.
        do @(negedge aclk); while (s_tready !== 1'b1);
        predicted = apply_operation(row.op, row.key, row.slot);
        pending_outcomes.push_back(row.typed ? row.want : predicted);
        @(posedge aclk);
    endtask

    task automatic random_burst(int count);
        int pick;
        logic [OP_W-1:0] op;
        logic [SLOT_W-1:0] s;
        repeat (count) begin
            // Insert often enough that the table fills well before the end.
            pick = $urandom_range(99);
            if (pick < 30)      op = OP_INSERT;
            else if (pick < 65) op = OP_FIND;
            else if (pick < 96) op = OP_READ;
            else                op = OP_UNUSED;
            s = SLOT_W'($urandom_range(255));
            if (op == OP_READ && table_count != 0 && $urandom_range(99) < 70)
                s = SLOT_W'($urandom_range(table_count - 1));
            send_op(make_row(op, pick_key(), s, 1'b0, 0, STAT_OK, 0));
        end
    endtask

    // Hold the input idle until every queued result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        $display("mismatch in result %0d: %s got %0h, want %0h",
                 results_seen, what, got, want);
    endtask

    // Compare one result transfer against the oldest prediction, field by field.
    task automatic check_result();
        outcome_t want;
        results_seen++;
        if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
            return;
        end
        want = pending_outcomes.pop_front();
        if (m_tdata[0 +: POS_W] !== want.position)
            report_mismatch("position", 64'(m_tdata[0 +: POS_W]), 64'(want.position));
        if (m_tdata[FOUND_BIT] !== want.found)
            report_mismatch("found", 64'(m_tdata[FOUND_BIT]), 64'(want.found));
        if (m_tdata[STATUS_LSB +: STATUS_W] !== want.status)
            report_mismatch("status", 64'(m_tdata[STATUS_LSB +: STATUS_W]), 64'(want.status));
        if (m_tdata[COUNT_LSB +: COUNT_OUT_W] !== want.entry_count)
            report_mismatch("entry_count", 64'(m_tdata[COUNT_LSB +: COUNT_OUT_W]),
                            64'(want.entry_count));
        if (m_tdata[RKEY_LSB +: KEY_WIDTH] !== want.read_key)
            report_mismatch("read_key", 64'(m_tdata[RKEY_LSB +: KEY_WIDTH]),
                            64'(want.read_key));
    endtask

    // Receiver: drive m_tready at each rising edge; a requested hold-off wins over
    // the random idling.
    always @(posedge aclk) begin
        if (hold_off_req && !hold_off_done) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: valid and ready seen at the falling edge mean a transfer at
    // the next rising edge, and the data is stable in between.
    always @(negedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) check_result();
    end

    // Stimulus and end of run.
    initial begin
        // Empty table, extremes of the key, duplicates at both ends and in the middle,
        // reads inside, at the edge of and beyond the stored count, and the unused op.
        directed.push_back(make_row(OP_FIND,   32'h0000_0000, 8'h00, 1'b1, -1, STAT_OK, 0));
        directed.push_back(make_row(OP_READ,   32'h0000_0000, 8'h00, 1'b1, 0, STAT_BAD_SLOT, 0));
        directed.push_back(make_row(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_INSERT, 32'h8000_0000, 8'h00, 1'b1, 0, STAT_OK, 1));
        directed.push_back(make_row(OP_INSERT, 32'h0000_0000, 8'h00, 1'b1, 0, STAT_OK, 2));
        directed.push_back(make_row(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 1'b1, 2, STAT_OK, 3));
        directed.push_back(make_row(OP_INSERT, 32'h8000_0000, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_INSERT, 32'h8000_0000, 8'hAA, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_INSERT, 32'h0000_0000, 8'h55, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_FIND,   32'h0000_0000, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_FIND,   32'hFFFF_FFFF, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_FIND,   32'h8000_0000, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_FIND,   32'h7FFF_FFFF, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_FIND,   32'h0000_0001, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_READ,   32'h0000_0000, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_READ,   32'hFFFF_FFFF, 8'h05, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_READ,   32'h0000_0000, 8'h06, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_READ,   32'h0000_0000, 8'hFF, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_INSERT, 32'hFFFF_FFFF, 8'h00, 1'b0, 0, STAT_OK, 0));
        directed.push_back(make_row(OP_UNUSED, 32'hAAAA_5555, 8'h55, 1'b0, 0, STAT_OK, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 19;
        recv_idle_pct <= 85;
        foreach (directed[i]) send_op(directed[i]);
        random_burst(BURST_ITEMS);
        drain_results();

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 85;
        recv_idle_pct <= 19;
        random_burst(BURST_ITEMS);
        drain_results();

        // No idling, but open with a long receiver hold-off so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_off_req <= 1'b1;
        random_burst(BURST_ITEMS);
        drain_results();

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** sorted_table_binary_search_insert_unit: PASSED **");
        end else begin
            $display("** sorted_table_binary_search_insert_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog: a time limit several times the slowest correct run
    // (every insert scanning and shifting a full table behind a stalled receiver).
    initial begin
        #50_000_000;
        $display("** sorted_table_binary_search_insert_unit: FAILED **");
        $finish;
    end

endmodule
